@@ rtl/rwpr_pkg.sv @@
// shared constants and types of the ramp-weighted pixel replicator
package rwpr_pkg;

  localparam int MAX_WIDTH   = 8192;
  localparam int MIN_WIDTH   = 2;
  localparam int FRAC_BITS   = 16;
  localparam int ACC_W       = 24;
  localparam int STEP_W      = 21;
  localparam int WIDTH_W     = 14;
  localparam int IN_COL_W    = 13;
  localparam int COL_W       = 18;
  localparam int COL_EXT_W   = COL_W + 1;
  localparam int MAX_RUN     = 32;
  localparam int RUN_W       = $clog2(MAX_RUN);
  localparam int PIX_W       = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 21;

  localparam logic [PIX_W-1:0]   ALPHA_OPAQUE = '1;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET  = WIDTH_W'(640);
  localparam logic [COL_W-1:0]   COL_MAX      = '1;

  typedef logic [PIX_W-1:0] pix_t;

  // one classified pixel waiting for replication
  typedef struct packed {
    pix_t                red;
    pix_t                green;
    pix_t                blue;
    logic [RUN_W-1:0]    run_n;
    logic [IN_COL_W-1:0] column;
    logic                row_end;
  } job_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAMP_STEP   = 2'd0,
    CFG_IMAGE_WIDTH = 2'd1
  } cfg_idx_e;

endpackage

@@ rtl/rwpr_front.sv @@
// front end: accepts pixels, steps the ramp and works out the copy count
module rwpr_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  rwpr_pkg::pix_t               red_i,
  input  rwpr_pkg::pix_t               green_i,
  input  rwpr_pkg::pix_t               blue_i,
  input  logic [rwpr_pkg::STEP_W-1:0]  cfg_step_i,
  input  logic [rwpr_pkg::WIDTH_W-1:0] cfg_width_i,
  input  logic                         full_i,
  output logic                         push_o,
  output rwpr_pkg::job_t               job_o
);
  import rwpr_pkg::*;

  logic [ACC_W-1:0]    acc_q, acc_d, acc_new;
  logic [IN_COL_W-1:0] col_q, col_d;
  logic [WIDTH_W-1:0]  w_eff, half, col_ext;
  logic [ACC_W:0]      acc_ext, step_ext, sum;
  logic [ACC_W-1:0]    rnd;
  logic [RUN_W-1:0]    run_n;
  logic                last_px, accept;

  assign accept     = in_valid_i && !full_i;
  assign in_stall_o = full_i;
  assign push_o     = accept;

  always_comb begin
    if (cfg_width_i < WIDTH_W'(MIN_WIDTH)) begin
      w_eff = WIDTH_W'(MIN_WIDTH);
    end else if (cfg_width_i > WIDTH_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = cfg_width_i;
    end
    half    = w_eff >> 1;
    col_ext = WIDTH_W'(col_q);
    last_px = WIDTH_W'(col_ext + WIDTH_W'(1)) >= w_eff;

    acc_ext  = {acc_q[ACC_W-1], acc_q};
    step_ext = (ACC_W+1)'(cfg_step_i);
    if (col_ext < half) begin
      sum = acc_ext + step_ext;
    end else begin
      sum = acc_ext - step_ext;
    end
    // saturate at the signed limits
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      acc_new = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_new = sum[ACC_W-1:0];
    end

    // round half up, negatives give a single copy
    rnd = ACC_W'(acc_new[ACC_W-2:FRAC_BITS]) + ACC_W'(acc_new[FRAC_BITS-1]);
    if (acc_new[ACC_W-1]) begin
      run_n = '0;
    end else if (rnd > ACC_W'(MAX_RUN - 1)) begin
      run_n = RUN_W'(MAX_RUN - 1);
    end else begin
      run_n = rnd[RUN_W-1:0];
    end

    acc_d = acc_q;
    col_d = col_q;
    if (accept) begin
      if (last_px) begin
        acc_d = '0;
        col_d = '0;
      end else begin
        acc_d = acc_new;
        col_d = col_q + IN_COL_W'(1);
      end
    end

    job_o.red     = red_i;
    job_o.green   = green_i;
    job_o.blue    = blue_i;
    job_o.run_n   = run_n;
    job_o.column  = col_q;
    job_o.row_end = last_px;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      col_q <= '0;
    end else begin
      acc_q <= acc_d;
      col_q <= col_d;
    end
  end

`ifndef ASSERT_OFF
  a_row_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_px |=> acc_q == '0 && col_q == '0)
    else $error("ramp state not cleared at end of row");
`endif

endmodule

@@ rtl/rwpr_queue.sv @@
// short queue of classified pixels between front and back end
module rwpr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rwpr_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output rwpr_pkg::job_t job_o
);
  import rwpr_pkg::*;

  job_t              store_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;

  assign full_o  = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign job_o   = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + (QPTR_W+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("word pushed into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("word popped from empty queue");
`endif

endmodule

@@ rtl/rwpr_back.sv @@
// back end: replays each pixel as a run of copies through an output register
module rwpr_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  rwpr_pkg::job_t               q_job_i,
  output logic                         pop_o,
  input  logic [rwpr_pkg::WIDTH_W-1:0] cfg_width_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output rwpr_pkg::pix_t               out_red_o,
  output rwpr_pkg::pix_t               out_green_o,
  output rwpr_pkg::pix_t               out_blue_o,
  output rwpr_pkg::pix_t               out_alpha_o,
  output logic [rwpr_pkg::COL_W-1:0]   out_column_o,
  output logic                         beyond_row_o,
  output logic                         run_last_o,
  output logic                         row_last_o
);
  import rwpr_pkg::*;

  // current run
  logic                 busy_q, busy_d;
  logic [RUN_W-1:0]     k_q, k_d, n_q;
  logic [COL_EXT_W-1:0] base_q;
  pix_t                 red_q, green_q, blue_q;
  logic                 row_end_q;
  logic [COL_W-1:0]     shift_q, shift_d;

  // output register
  logic                 out_valid_q;
  pix_t                 out_red_q, out_green_q, out_blue_q;
  logic [COL_W-1:0]     out_column_q;
  logic                 out_beyond_q, out_run_last_q, out_row_last_q;

  logic                 out_free, emit, last_copy, load;
  logic [COL_EXT_W-1:0] col, shift_sum, dbl;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign emit      = busy_q && out_free;
  assign last_copy = k_q == n_q;
  assign load      = q_valid_i && (!busy_q || (emit && last_copy));
  assign pop_o     = load;

  always_comb begin
    col       = base_q + COL_EXT_W'(k_q);
    dbl       = COL_EXT_W'({cfg_width_i, 1'b0});
    shift_sum = COL_EXT_W'(shift_q) + COL_EXT_W'(q_job_i.run_n);

    busy_d = busy_q;
    k_d    = k_q;
    if (emit) begin
      if (last_copy) begin
        busy_d = 1'b0;
      end else begin
        k_d = k_q + RUN_W'(1);
      end
    end
    if (load) begin
      busy_d = 1'b1;
      k_d    = '0;
    end

    shift_d = shift_q;
    if (load) begin
      if (q_job_i.row_end) begin
        shift_d = '0;
      end else if (shift_sum > COL_EXT_W'(COL_MAX)) begin
        shift_d = COL_MAX;
      end else begin
        shift_d = shift_sum[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      k_q         <= '0;
      shift_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      k_q     <= k_d;
      shift_q <= shift_d;
      if (out_free) begin
        out_valid_q <= busy_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      n_q       <= q_job_i.run_n;
      base_q    <= COL_EXT_W'(q_job_i.column) + COL_EXT_W'(shift_q);
      red_q     <= q_job_i.red;
      green_q   <= q_job_i.green;
      blue_q    <= q_job_i.blue;
      row_end_q <= q_job_i.row_end;
    end
    if (emit) begin
      out_red_q      <= red_q;
      out_green_q    <= green_q;
      out_blue_q     <= blue_q;
      out_column_q   <= (col > COL_EXT_W'(COL_MAX)) ? COL_MAX : col[COL_W-1:0];
      out_beyond_q   <= col >= dbl;
      out_run_last_q <= last_copy;
      out_row_last_q <= last_copy && row_end_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_red_o    = out_red_q;
  assign out_green_o  = out_green_q;
  assign out_blue_o   = out_blue_q;
  assign out_alpha_o  = ALPHA_OPAQUE;
  assign out_column_o = out_column_q;
  assign beyond_row_o = out_beyond_q;
  assign run_last_o   = out_run_last_q;
  assign row_last_o   = out_row_last_q;

`ifndef ASSERT_OFF
  a_copy_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> k_q <= n_q)
    else $error("copy index past run length");
  a_run_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && out_valid_q && out_stall_i |=> busy_q && $stable(k_q))
    else $error("run advanced while output stalled");
`endif

endmodule

@@ rtl/ramp_weighted_pixel_replicator_unit.sv @@
// top level of the ramp-weighted pixel replicator
//
// pixels enter on in_valid_i / in_stall_o with red_i, green_i, blue_i, in row order.
// each pixel leaves as a run of 1 to 32 copies on out_valid_o / out_stall_i, one
// copy per cycle unless stalled, with alpha 255, the output column and the run
// and row flags. a word moves when valid is high and stall is low on that channel.
// registers are written on cfg_valid_i / cfg_ready_o (always ready): index 0 is
// ramp_step, index 1 is image_width; other indexes are ignored. write only while idle.
// when the back end is free, a pixel that is taken passes through the queue, the
// run register and the output register. a pixel with count n fills the output
// with n+1 copies; the output register sets the sustained rate of one copy
// per cycle, and the front end takes one pixel per cycle while the four-word
// queue has room. in_stall_o rises only when that queue is full.
// reset clears the ramp, column and shift state, empties the queue and sets
// ramp_step to 0 and image_width to 640. when the receiver stalls, the current
// copy holds on the outputs and the queue fills behind it.
module ramp_weighted_pixel_replicator_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rwpr_pkg::pix_t                  red_i,
  input  rwpr_pkg::pix_t                  green_i,
  input  rwpr_pkg::pix_t                  blue_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rwpr_pkg::pix_t                  out_red_o,
  output rwpr_pkg::pix_t                  out_green_o,
  output rwpr_pkg::pix_t                  out_blue_o,
  output rwpr_pkg::pix_t                  out_alpha_o,
  output logic [rwpr_pkg::COL_W-1:0]      out_column_o,
  output logic                            beyond_row_o,
  output logic                            run_last_o,
  output logic                            row_last_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rwpr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rwpr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rwpr_pkg::*;

  logic [STEP_W-1:0]  ramp_step_q;
  logic [WIDTH_W-1:0] image_width_q;

  logic full, push, q_valid, pop;
  job_t front_job, head_job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_step_q   <= '0;
      image_width_q <= WIDTH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RAMP_STEP:   ramp_step_q   <= cfg_data_i[STEP_W-1:0];
        CFG_IMAGE_WIDTH: image_width_q <= cfg_data_i[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  rwpr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .cfg_step_i  (ramp_step_q),
    .cfg_width_i (image_width_q),
    .full_i      (full),
    .push_o      (push),
    .job_o       (front_job)
  );

  rwpr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  rwpr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_job_i      (head_job),
    .pop_o        (pop),
    .cfg_width_i  (image_width_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_red_o    (out_red_o),
    .out_green_o  (out_green_o),
    .out_blue_o   (out_blue_o),
    .out_alpha_o  (out_alpha_o),
    .out_column_o (out_column_o),
    .beyond_row_o (beyond_row_o),
    .run_last_o   (run_last_o),
    .row_last_o   (row_last_o)
  );

endmodule

@@ dv/rwpr_copy_checker.sv @@
// copy predictor and scoreboard for the ramp-weighted pixel replicator
`timescale 1ns / 100ps

module rwpr_copy_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  rwpr_pkg::pix_t                  red_i,
  input  rwpr_pkg::pix_t                  green_i,
  input  rwpr_pkg::pix_t                  blue_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  rwpr_pkg::pix_t                  out_red_i,
  input  rwpr_pkg::pix_t                  out_green_i,
  input  rwpr_pkg::pix_t                  out_blue_i,
  input  rwpr_pkg::pix_t                  out_alpha_i,
  input  logic [rwpr_pkg::COL_W-1:0]      out_column_i,
  input  logic                            beyond_row_i,
  input  logic                            run_last_i,
  input  logic                            row_last_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [rwpr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rwpr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              mismatch_count_o,
  output int                              pending_o
);
  import rwpr_pkg::*;

  localparam int ACC_TOP    = 2 ** (ACC_W - 1) - 1;
  localparam int ACC_BOTTOM = -(2 ** (ACC_W - 1));
  localparam int HALF_LSB   = 1 << (FRAC_BITS - 1);
  localparam int COL_TOP    = 2 ** COL_W - 1;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    pix_t             red;
    pix_t             green;
    pix_t             blue;
    pix_t             alpha;
    logic [COL_W-1:0] column;
    logic             beyond;
    logic             run_last;
    logic             row_last;
  } copy_t;

  copy_t copies_due[$];
  copy_t seen_copy;
  copy_t want_copy;
  int    mismatches;

  logic [STEP_W-1:0]       step_q;
  logic [WIDTH_W-1:0]      width_q;
  logic signed [ACC_W-1:0] ramp_q;
  logic [IN_COL_W-1:0]     column_q;
  logic [COL_W-1:0]        shift_q;

  // one input pixel becomes a run of copies, then the row state moves on
  task automatic replicate_pixel(input pix_t r, input pix_t g, input pix_t b);
    int    eff_width;
    int    half;
    int    ramp;
    int    runs;
    int    base;
    int    dbl;
    int    col;
    int    shift_sum;
    bit    row_end;
    copy_t c;
    eff_width = int'(width_q);
    if (eff_width < MIN_WIDTH) eff_width = MIN_WIDTH;
    if (eff_width > MAX_WIDTH) eff_width = MAX_WIDTH;
    half    = eff_width / 2;
    row_end = (int'(column_q) + 1 >= eff_width);
    ramp    = int'(ramp_q);
    if (int'(column_q) < half) ramp = ramp + int'(step_q);
    else ramp = ramp - int'(step_q);
    if (ramp > ACC_TOP) ramp = ACC_TOP;
    if (ramp < ACC_BOTTOM) ramp = ACC_BOTTOM;
    ramp_q = ramp[ACC_W-1:0];
    if (ramp < 0) begin
      runs = 0;
    end else begin
      runs = (ramp + HALF_LSB) >> FRAC_BITS;
      if (runs > MAX_RUN - 1) runs = MAX_RUN - 1;
    end
    base = int'(column_q) + int'(shift_q);
    // the out-of-row test uses the raw register, not the clamped width
    dbl  = 2 * int'(width_q);
    for (int k = 0; k <= runs; k++) begin
      col        = base + k;
      c.red      = r;
      c.green    = g;
      c.blue     = b;
      c.alpha    = ALPHA_OPAQUE;
      c.column   = COL_W'((col > COL_TOP) ? COL_TOP : col);
      c.beyond   = (col >= dbl);
      c.run_last = (k == runs);
      c.row_last = (k == runs) && row_end;
      copies_due.push_back(c);
    end
    if (row_end) begin
      ramp_q   = '0;
      column_q = '0;
      shift_q  = '0;
    end else begin
      column_q  = column_q + IN_COL_W'(1);
      shift_sum = int'(shift_q) + runs;
      shift_q   = COL_W'((shift_sum > COL_TOP) ? COL_TOP : shift_sum);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     = '0;
      width_q    = WIDTH_RESET;
      ramp_q     = '0;
      column_q   = '0;
      shift_q    = '0;
      mismatches = 0;
      copies_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_RAMP_STEP:   step_q  = cfg_data_i[STEP_W-1:0];
          CFG_IMAGE_WIDTH: width_q = cfg_data_i[WIDTH_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        seen_copy = '{out_red_i, out_green_i, out_blue_i, out_alpha_i, out_column_i,
                      beyond_row_i, run_last_i, row_last_i};
        if (copies_due.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("copy with nothing expected: rgba %h %h %h %h col %0d flags %b%b%b",
                     seen_copy.red, seen_copy.green, seen_copy.blue, seen_copy.alpha,
                     seen_copy.column, seen_copy.beyond, seen_copy.run_last,
                     seen_copy.row_last);
          mismatches++;
        end else begin
          want_copy = copies_due.pop_front();
          if (seen_copy.red !== want_copy.red || seen_copy.green !== want_copy.green ||
              seen_copy.blue !== want_copy.blue || seen_copy.alpha !== want_copy.alpha ||
              seen_copy.column !== want_copy.column ||
              seen_copy.beyond !== want_copy.beyond ||
              seen_copy.run_last !== want_copy.run_last ||
              seen_copy.row_last !== want_copy.row_last) begin
            if (mismatches < REPORT_MAX) begin
              $display("copy mismatch at %0t: beyond/run_last/row_last shown as flags",
                       $realtime);
              $display("  expected rgba %h %h %h %h col %0d flags %b%b%b",
                       want_copy.red, want_copy.green, want_copy.blue, want_copy.alpha,
                       want_copy.column, want_copy.beyond, want_copy.run_last,
                       want_copy.row_last);
              $display("  actual   rgba %h %h %h %h col %0d flags %b%b%b",
                       seen_copy.red, seen_copy.green, seen_copy.blue, seen_copy.alpha,
                       seen_copy.column, seen_copy.beyond, seen_copy.run_last,
                       seen_copy.row_last);
            end
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) replicate_pixel(red_i, green_i, blue_i);
    end
    pending_o        <= copies_due.size();
    mismatch_count_o <= mismatches;
  end

endmodule

@@ dv/ramp_weighted_pixel_replicator_unit_test.sv @@
// stimulus, clock, reset and verdict for the ramp-weighted pixel replicator
`timescale 1ns / 100ps

module ramp_weighted_pixel_replicator_unit_test;
  import rwpr_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 4;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 16;
  localparam int HOLD_CYCLES   = 64;
  localparam int HOLD_PIXELS   = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam logic [STEP_W-1:0]    STEP_TOP     = '1;
  localparam logic [WIDTH_W-1:0]   WIDTH_TOP    = '1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  pix_t                  red       = '0;
  pix_t                  green     = '0;
  pix_t                  blue      = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  pix_t                  out_red;
  pix_t                  out_green;
  pix_t                  out_blue;
  pix_t                  out_alpha;
  logic [COL_W-1:0]      out_column;
  logic                  beyond_row;
  logic                  run_last;
  logic                  row_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int   mismatch_count;
  int   copies_pending;
  int   pixels_sent   = 0;
  int   send_idle_pct = 14;
  int   recv_idle_pct = 84;
  int   quiet_cycles  = 0;
  logic hold_go       = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  ramp_weighted_pixel_replicator_unit dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .red_i        (red),
    .green_i      (green),
    .blue_i       (blue),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_red_o    (out_red),
    .out_green_o  (out_green),
    .out_blue_o   (out_blue),
    .out_alpha_o  (out_alpha),
    .out_column_o (out_column),
    .beyond_row_o (beyond_row),
    .run_last_o   (run_last),
    .row_last_o   (row_last),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  rwpr_copy_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .red_i            (red),
    .green_i          (green),
    .blue_i           (blue),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_red_i        (out_red),
    .out_green_i      (out_green),
    .out_blue_i       (out_blue),
    .out_alpha_i      (out_alpha),
    .out_column_i     (out_column),
    .beyond_row_i     (beyond_row),
    .run_last_i       (run_last),
    .row_last_i       (row_last),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .pending_o        (copies_pending)
  );

  // receiver: random stalls, or one long hold-off when asked
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // watchdog on cycles in which no word moves on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // leaves cfg_valid high so back-to-back writes need no extra step
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_ramp(input logic [STEP_W-1:0] step, input logic [WIDTH_W-1:0] width);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'($urandom);
    word[WIDTH_W-1:0] = width;
    write_reg(CFG_RAMP_STEP, CFG_DATA_W'(step));
    write_reg(CFG_IMAGE_WIDTH, word);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(input pix_t r, input pix_t g, input pix_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    red      <= r;
    green    <= g;
    blue     <= b;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
  endtask

  task automatic send_run(input int count);
    repeat (count) send_pixel(pix_t'($urandom), pix_t'($urandom), pix_t'($urandom));
  endtask

  // sender pauses until every expected copy has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (copies_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // new register setting then a burst of pixels; rows carry on across bursts
  task automatic random_segment();
    logic [WIDTH_W-1:0] width;
    logic [STEP_W-1:0]  step;
    int                 half;
    case ($urandom_range(9))
      0:       width = WIDTH_W'($urandom_range(1));
      1:       width = $urandom_range(1) ? WIDTH_TOP : WIDTH_W'(MAX_WIDTH);
      2:       width = WIDTH_W'($urandom_range(25, int'(WIDTH_TOP)));
      default: width = WIDTH_W'($urandom_range(2, 24));
    endcase
    half = (width < MIN_WIDTH) ? 1 : (width > MAX_WIDTH) ? MAX_WIDTH / 2 : width / 2;
    // mostly steps that keep the runs a few copies long at the row centre
    case ($urandom_range(7))
      0:       step = STEP_W'($urandom);
      1:       step = STEP_TOP;
      2:       step = '0;
      default: step = STEP_W'($urandom_range((6 << FRAC_BITS) / half));
    endcase
    drain();
    set_ramp(step, width);
    send_run($urandom_range(1, 40));
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting: zero step, so single copies
    send_pixel('0, '0, '0);
    send_pixel('1, '1, '1);
    send_pixel(8'hA5, 8'h5A, 8'h3C);
    drain();
    // unused indexes must be ignored
    write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));
    // width 0 acts as 2 and cuts the open row; step 1.5 rounds up to 2
    set_ramp(STEP_W'(3 << (FRAC_BITS - 1)), '0);
    send_run(3);
    drain();
    // width 1 acts as 2; step of exactly one half rounds up to 1
    set_ramp(STEP_W'(1 << (FRAC_BITS - 1)), WIDTH_W'(1));
    send_run(2);
    drain();
    // flat first half, then full step down into negative saturation
    set_ramp('0, WIDTH_W'(12));
    send_run(6);
    drain();
    set_ramp(STEP_TOP, WIDTH_W'(12));
    send_run(6);
    drain();
    // full step up: run length capped and positive saturation
    set_ramp(STEP_TOP, WIDTH_W'(10));
    send_run(5);

    while (pixels_sent < 120) random_segment();

    drain();
    send_idle_pct = 84;
    recv_idle_pct <= 14;
    while (pixels_sent < 215) random_segment();

    drain();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    random_segment();
    // long receiver hold-off while pixels keep coming, so the input stalls
    hold_go <= 1'b1;
    send_run(HOLD_PIXELS);
    while (pixels_sent < 260) random_segment();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && copies_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rwpr_pkg.sv
rtl/rwpr_front.sv
rtl/rwpr_queue.sv
rtl/rwpr_back.sv
rtl/ramp_weighted_pixel_replicator_unit.sv
dv/rwpr_copy_checker.sv
dv/ramp_weighted_pixel_replicator_unit_test.sv
